[hdl/assert_macros.svh]
// shared assertion macros for the deque engine checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/sde_pkg.sv]
package sde_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 7;

  // operation codes
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_DELETE     = 3'd4,
    ACT_SEARCH     = 3'd5,
    ACT_SWAP       = 3'd6
  } action_e_t;

  // what a cell loads at the next edge
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD_A,
    CELL_LOAD_B
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [KEY_W-1:0] key_a;
    logic signed [KEY_W-1:0] key_b;
  } in_item_t;

  typedef struct packed {
    logic                    ok;
    logic signed [KEY_W-1:0] key_out;
    logic [COUNT_W-1:0]      count;
  } out_item_t;

endpackage

[hdl/sde_cell.sv]
module sde_cell
  import sde_pkg::*;
(
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic signed [KEY_W-1:0] key_left,
  input  logic signed [KEY_W-1:0] key_right,
  input  logic signed [KEY_W-1:0] key_a,
  input  logic signed [KEY_W-1:0] key_b,
  output logic signed [KEY_W-1:0] key_q,
  output logic                    match_a,
  output logic                    match_b
);

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;

  // next key from neighbors or the broadcast keys
  always_comb begin
    case (cmd)
      CELL_HOLD:       key_nxt = key_r;
      CELL_FROM_LEFT:  key_nxt = key_left;
      CELL_FROM_RIGHT: key_nxt = key_right;
      CELL_LOAD_A:     key_nxt = key_a;
      CELL_LOAD_B:     key_nxt = key_b;
      default:         key_nxt = key_r;
    endcase
  end

  // stored key, no reset
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  // local compare against both broadcast keys
  assign key_q   = key_r;
  assign match_a = (key_r == key_a);
  assign match_b = (key_r == key_b);

endmodule

[hdl/searchable_deque_engine_top.sv]
// flow: item registered in op_r at transfer, result in out_data_r when the output
// can take it; a new item waits until the last result is committed; each item takes
// one compare-and-shift pass through the row of key cells after it is taken
// reset: synchronous, clears the key count and handshake state; keys are not
// cleared and there is no clearing pass, so an item can be taken right after reset
module searchable_deque_engine_top
  import sde_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t    state_r, state_nxt;
  in_item_t  op_r;
  logic [CW-1:0] count_r, count_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t res;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0] raw_a, raw_b, occ, tail;
  logic [CAPACITY-1:0] ma, mb, low_a, low_b, first_a, first_b, ge_a;
  cell_cmd_t cmd [CAPACITY];
  logic found_a, found_b, not_full, not_empty, commit;
  logic [CW-1:0] count_m1;

  // row of key cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [CW-1:0] POS = CW'(g);
    logic signed [KEY_W-1:0] kl, kr;

    if (g == 0) begin : g_first
      assign kl = op_r.key_a;
    end else begin : g_mid
      assign kl = cell_key[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign kr = cell_key[g];
    end else begin : g_inner
      assign kr = cell_key[g+1];
    end

    assign occ[g]  = (POS < count_r);
    assign tail[g] = (POS == count_r);

    sde_cell u_cell (
      .clk       (clk),
      .cmd       (cmd[g]),
      .key_left  (kl),
      .key_right (kr),
      .key_a     (op_r.key_a),
      .key_b     (op_r.key_b),
      .key_q     (cell_key[g]),
      .match_a   (raw_a[g]),
      .match_b   (raw_b[g])
    );
  end

  // first match of each key and the positions at or after the first key_a match
  always_comb begin
    ma      = raw_a & occ;
    mb      = raw_b & occ;
    low_a   = ma ^ (ma - CAPACITY'(1));
    low_b   = mb ^ (mb - CAPACITY'(1));
    first_a = low_a & ma;
    first_b = low_b & mb;
    ge_a    = ~low_a | first_a;
    found_a = |ma;
    found_b = |mb;
  end

  assign not_full  = (count_r < CW'(CAPACITY));
  assign not_empty = (count_r != '0);
  assign count_m1  = count_r - CW'(1);
  assign commit    = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  // result, count update and per-cell commands
  always_comb begin
    res.ok      = 1'b0;
    res.key_out = '0;
    count_nxt   = count_r;
    for (int i = 0; i < CAPACITY; i++) begin
      cmd[i] = CELL_HOLD;
    end
    case (op_r.action)
      ACT_PUSH_FRONT: begin
        if (not_full) begin
          res.ok    = 1'b1;
          count_nxt = count_r + CW'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            cmd[i] = CELL_FROM_LEFT;
          end
        end
      end
      ACT_PUSH_BACK: begin
        if (not_full) begin
          res.ok    = 1'b1;
          count_nxt = count_r + CW'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            if (tail[i]) cmd[i] = CELL_LOAD_A;
          end
        end
      end
      ACT_POP_FRONT: begin
        if (not_empty) begin
          res.ok      = 1'b1;
          res.key_out = cell_key[0];
          count_nxt   = count_m1;
          for (int i = 0; i < CAPACITY; i++) begin
            cmd[i] = CELL_FROM_RIGHT;
          end
        end
      end
      ACT_POP_BACK: begin
        if (not_empty) begin
          res.ok      = 1'b1;
          res.key_out = cell_key[count_m1[IW-1:0]];
          count_nxt   = count_m1;
        end
      end
      ACT_DELETE: begin
        if (found_a) begin
          res.ok    = 1'b1;
          count_nxt = count_m1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (ge_a[i]) cmd[i] = CELL_FROM_RIGHT;
          end
        end
      end
      ACT_SEARCH: begin
        res.ok = found_a;
      end
      ACT_SWAP: begin
        if (found_a && found_b) begin
          res.ok = 1'b1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (first_a[i]) cmd[i] = CELL_LOAD_B;
            else if (first_b[i]) cmd[i] = CELL_LOAD_A;
          end
        end
      end
      default: begin
        res.ok = 1'b0;
      end
    endcase
    // cells only move when the result can be written
    if (!commit) begin
      count_nxt = count_r;
      for (int i = 0; i < CAPACITY; i++) begin
        cmd[i] = CELL_HOLD;
      end
    end
    res.count = COUNT_W'(count_nxt);
  end

  // control sequencing and output register handshake
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (commit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) op_r <= in_data;
    if (commit) out_data_r <= res;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/sde_checker.sv]
`include "assert_macros.svh"

module sde_checker
  import sde_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a result waiting at the output holds until it is taken
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // one item at a time: no new transfer right after a transfer
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  // a nonzero popped key only comes with success
  `ASSERT_SAME(a_key_needs_ok, clk, rst_n, out_valid && (out_data.key_out != 0), out_data.ok)

  // a taken item produces its result only after it is executed, not straight from the transfer
  `ASSERT_NEXT(a_no_early_result, clk, rst_n, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind searchable_deque_engine_top sde_checker u_sde_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
